// ===== rtl/odbm_pkg.sv =====
// Shared types and constants for the omni drive button mixer.
package odbm_pkg;

  localparam int NUM_WHEELS = 4;

  // Bit i set: the button's vector is +1 on wheel i, else -1.
  localparam logic [NUM_WHEELS-1:0] PAT_FORWARD      = 4'b1111;
  localparam logic [NUM_WHEELS-1:0] PAT_BACKWARD     = 4'b0000;
  localparam logic [NUM_WHEELS-1:0] PAT_STRAFE_LEFT  = 4'b0110;
  localparam logic [NUM_WHEELS-1:0] PAT_STRAFE_RIGHT = 4'b1001;
  localparam logic [NUM_WHEELS-1:0] PAT_TURN_RIGHT   = 4'b0101;
  localparam logic [NUM_WHEELS-1:0] PAT_TURN_LEFT    = 4'b1010;

  localparam logic [7:0]  SPEED_MAX      = 8'd255;
  localparam logic [7:0]  SPEED_RESET    = 8'd200;
  localparam logic [2:0]  MAP_LOW        = 3'd1;
  localparam logic [2:0]  MAP_HIGH       = 3'd4;
  localparam logic [3:0]  INVERT_RESET   = 4'd0;
  localparam logic [7:0]  STEP_RESET     = 8'd25;
  localparam logic [15:0] INTERVAL_RESET = 16'd200;
  localparam logic [7:0]  MIN_RESET      = 8'd50;

  // x / 3 == (x * 683) >> 11 for x < 2047
  localparam logic [10:0] RECIP3       = 11'd683;
  localparam int          RECIP3_SHIFT = 11;

  localparam int CFG_DATA_W = 16;

  typedef enum logic [2:0] {
    REG_MAP0,
    REG_MAP1,
    REG_MAP2,
    REG_MAP3,
    REG_INVERT,
    REG_STEP,
    REG_INTERVAL,
    REG_MIN_SPEED
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_PROD,
    ST_DIV,
    ST_DRIVE
  } ctl_state_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        home;
    logic        plus;
    logic        minus;
    logic        forward;
    logic        backward;
    logic        strafe_left;
    logic        strafe_right;
    logic        turn_right;
    logic        turn_left;
  } in_beat_t;

  typedef struct packed {
    logic       reverse_motor1;
    logic       reverse_motor2;
    logic       reverse_motor3;
    logic       reverse_motor4;
    logic [7:0] duty_motor1;
    logic [7:0] duty_motor2;
    logic [7:0] duty_motor3;
    logic [7:0] duty_motor4;
    logic [7:0] speed_now;
  } out_beat_t;

  typedef struct packed {
    logic latch;
    logic mix;
    logic prod;
    logic div;
    logic drive;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

  // Signed contribution of one button to one wheel: -1, 0 or +1.
  function automatic logic signed [2:0] button_term(input logic pressed, input logic pos);
    logic signed [2:0] t;
    t = 3'sd0;
    if (pressed) t = pos ? 3'sd1 : -3'sd1;
    return t;
  endfunction

endpackage

// ===== rtl/odbm_in_if.sv =====
// Report channel: valid/ready handshake carrying one controller report.
interface odbm_in_if
  import odbm_pkg::*;
;
  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/odbm_out_if.sv =====
// Result channel: valid/ready handshake carrying motor commands and speed.
interface odbm_out_if
  import odbm_pkg::*;
;
  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/odbm_ctrl.sv =====
// Sequencer: steps one report through mix, product, divide and drive.
module odbm_ctrl
  import odbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_MIX;
        end
      end
      ST_MIX: begin
        cmd.mix   = 1'b1;
        state_nxt = ST_PROD;
      end
      ST_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = ST_DRIVE;
      end
      ST_DRIVE: begin
        // hold until the result register can take a new beat
        if (!status.out_busy) begin
          cmd.drive = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/odbm_datapath.sv =====
// Datapath: settings, speed state, wheel mixing, scaling and motor encoding.
module odbm_datapath
  import odbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  in_beat_t              in_data,
  input  ctl_cmd_t              cmd,
  output dp_status_t            status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_beat_t             out_data
);

  // settings
  logic [2:0]  map_r [NUM_WHEELS];
  logic [3:0]  invert_r;
  logic [7:0]  step_r;
  logic [15:0] interval_r;
  logic [7:0]  min_speed_r;

  // persistent state
  logic [7:0]  speed_r;
  logic [31:0] last_r;
  logic        rev_r  [NUM_WHEELS];
  logic [7:0]  duty_r [NUM_WHEELS];
  logic        out_valid_r;
  out_beat_t   out_r;

  // per-report working registers
  in_beat_t    in_r;
  logic        neg_r  [NUM_WHEELS];
  logic [1:0]  abs_r  [NUM_WHEELS];
  logic [1:0]  mx_r;
  logic [9:0]  prod_r [NUM_WHEELS];
  logic [7:0]  mag_r  [NUM_WHEELS];

  // ---------------- mix stage ----------------
  logic [31:0]       elapsed;
  logic              may_change;
  logic [8:0]        up_sum;
  logic [8:0]        down_diff;
  logic [7:0]        speed_nxt;
  logic signed [2:0] wsum [NUM_WHEELS];
  logic              neg_nxt [NUM_WHEELS];
  logic [1:0]        abs_nxt [NUM_WHEELS];
  logic [1:0]        mx_nxt;

  assign elapsed    = in_r.now_ms - last_r;
  assign may_change = !in_r.home && (elapsed > {16'd0, interval_r}) &&
                      (in_r.plus || in_r.minus);
  assign up_sum     = {1'b0, speed_r} + {1'b0, step_r};
  assign down_diff  = {1'b0, speed_r} - {1'b0, step_r};

  always_comb begin
    if (in_r.plus) begin
      speed_nxt = up_sum[8] ? SPEED_MAX : up_sum[7:0];
    end else if (down_diff[8] || (down_diff[7:0] < min_speed_r)) begin
      speed_nxt = min_speed_r;
    end else begin
      speed_nxt = down_diff[7:0];
    end
  end

  always_comb begin
    mx_nxt = 2'd0;
    for (int w = 0; w < NUM_WHEELS; w++) begin
      wsum[w] = button_term(in_r.forward, PAT_FORWARD[w]) +
                button_term(in_r.backward, PAT_BACKWARD[w]) +
                button_term(in_r.strafe_left, PAT_STRAFE_LEFT[w]) +
                button_term(in_r.strafe_right, PAT_STRAFE_RIGHT[w]) +
                button_term(in_r.turn_right, PAT_TURN_RIGHT[w]) +
                button_term(in_r.turn_left, PAT_TURN_LEFT[w]);
      neg_nxt[w] = wsum[w][2];
      abs_nxt[w] = wsum[w][2] ? 2'(-wsum[w]) : wsum[w][1:0];
      // home forces every wheel to zero
      if (in_r.home) begin
        neg_nxt[w] = 1'b0;
        abs_nxt[w] = 2'd0;
      end
      if (abs_nxt[w] > mx_nxt) mx_nxt = abs_nxt[w];
    end
  end

  // ---------------- divide stage ----------------
  logic [20:0] third [NUM_WHEELS];
  logic [7:0]  mag_nxt [NUM_WHEELS];

  always_comb begin
    for (int w = 0; w < NUM_WHEELS; w++) begin
      third[w] = {11'd0, prod_r[w]} * {10'd0, RECIP3};
      case (mx_r)
        2'd1:    mag_nxt[w] = prod_r[w][7:0];
        2'd2:    mag_nxt[w] = prod_r[w][8:1];
        2'd3:    mag_nxt[w] = third[w][RECIP3_SHIFT +: 8];
        default: mag_nxt[w] = 8'd0;
      endcase
    end
  end

  // ---------------- drive stage ----------------
  logic       rev_nxt  [NUM_WHEELS];
  logic [7:0] duty_nxt [NUM_WHEELS];
  logic       cmd_neg;
  logic [1:0] phys;

  always_comb begin
    cmd_neg = 1'b0;
    phys    = 2'd0;
    for (int p = 0; p < NUM_WHEELS; p++) begin
      rev_nxt[p]  = rev_r[p];
      duty_nxt[p] = duty_r[p];
    end
    // later wheels override earlier ones on a shared motor
    for (int w = 0; w < NUM_WHEELS; w++) begin
      if (map_r[w] inside {[MAP_LOW:MAP_HIGH]}) begin
        phys    = 2'(map_r[w] - MAP_LOW);
        cmd_neg = neg_r[w] ^ invert_r[w];
        if (mag_r[w] == 8'd0) begin
          rev_nxt[phys]  = 1'b0;
          duty_nxt[phys] = 8'd0;
        end else if (cmd_neg) begin
          rev_nxt[phys]  = 1'b1;
          duty_nxt[phys] = SPEED_MAX - mag_r[w];
        end else begin
          rev_nxt[phys]  = 1'b0;
          duty_nxt[phys] = mag_r[w];
        end
      end
    end
  end

  // ---------------- control and state registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
        map_r[w]  <= 3'(w + 1);
        rev_r[w]  <= 1'b0;
        duty_r[w] <= 8'd0;
      end
      invert_r    <= INVERT_RESET;
      step_r      <= STEP_RESET;
      interval_r  <= INTERVAL_RESET;
      min_speed_r <= MIN_RESET;
      speed_r     <= SPEED_RESET;
      last_r      <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_MAP0, REG_MAP1, REG_MAP2, REG_MAP3: map_r[cfg_index[1:0]] <= cfg_wdata[2:0];
          REG_INVERT:    invert_r    <= cfg_wdata[3:0];
          REG_STEP:      step_r      <= cfg_wdata[7:0];
          REG_INTERVAL:  interval_r  <= cfg_wdata[15:0];
          REG_MIN_SPEED: min_speed_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (cmd.mix && may_change) begin
        speed_r <= speed_nxt;
        last_r  <= in_r.now_ms;
      end
      if (cmd.drive) begin
        for (int p = 0; p < NUM_WHEELS; p++) begin
          rev_r[p]  <= rev_nxt[p];
          duty_r[p] <= duty_nxt[p];
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (cmd.latch) in_r <= in_data;
    if (cmd.mix) begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
        neg_r[w] <= neg_nxt[w];
        abs_r[w] <= abs_nxt[w];
      end
      mx_r <= mx_nxt;
    end
    if (cmd.prod) begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
        prod_r[w] <= {2'd0, speed_r} * {8'd0, abs_r[w]};
      end
    end
    if (cmd.div) begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
        mag_r[w] <= mag_nxt[w];
      end
    end
    if (cmd.drive) begin
      out_r.reverse_motor1 <= rev_nxt[0];
      out_r.reverse_motor2 <= rev_nxt[1];
      out_r.reverse_motor3 <= rev_nxt[2];
      out_r.reverse_motor4 <= rev_nxt[3];
      out_r.duty_motor1    <= duty_nxt[0];
      out_r.duty_motor2    <= duty_nxt[1];
      out_r.duty_motor3    <= duty_nxt[2];
      out_r.duty_motor4    <= duty_nxt[3];
      out_r.speed_now      <= speed_r;
    end
  end

  assign status.out_busy = out_valid_r && !out_ready;
  assign out_valid       = out_valid_r;
  assign out_data        = out_r;

endmodule

// ===== rtl/omni_drive_button_mixer.sv =====
// Sequence: an accepted report is registered in turn by the mix, product, divide and drive
//   steps; the drive step waits while the previous result beat is stalled.
// One report at a time: a new report is accepted only once the controller's sequence of
//   states has taken the last one through drive; it is taken while the previous result beat waits in its register.
// Reset (rst_n low, synchronous): settings to defaults, speed 200, motors stopped,
//   result register empty.
// Top level of the omni drive button mixer.
module omni_drive_button_mixer
  import odbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  odbm_in_if.sink               in_ch,
  odbm_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  odbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  odbm_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_ch.data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );

endmodule

// ===== rtl/odbm_checker.sv =====
// Port-level checks for the omni drive button mixer, bound to the top level.
module odbm_checker
  import odbm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one report at a time: no accept on the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("report accepted back to back");

  // reverse always carries a nonzero magnitude, so duty never reaches full scale
  a_reverse_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.reverse_motor1 && out_data.duty_motor1 == SPEED_MAX) &&
                  !(out_data.reverse_motor2 && out_data.duty_motor2 == SPEED_MAX) &&
                  !(out_data.reverse_motor3 && out_data.duty_motor3 == SPEED_MAX) &&
                  !(out_data.reverse_motor4 && out_data.duty_motor4 == SPEED_MAX))
    else $error("reverse motor with full duty");

endmodule

bind omni_drive_button_mixer odbm_checker u_odbm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
